// File: rtl/dwpi_pkg.sv
// ----------------------------------------------------------------------------
// dwpi_pkg
// Shared types and constants for the dual wheel PI speed controller.
// ----------------------------------------------------------------------------
package dwpi_pkg;

	localparam int ENCODER_BITS_DEF = 32;

	localparam int ENC_IN_W  = 32;
	localparam int TGT_W     = 10;
	localparam int SPEED_W   = 16;
	localparam int RAMP_W    = 12;	// ramp +/- step, no overflow
	localparam int ERR_W     = 17;
	localparam int INTEG_W   = 11;
	localparam int SUM_W     = 18;
	localparam int GAIN_W    = 10;
	localparam int STEP_W    = 8;
	localparam int LIM_W     = 10;
	localparam int CFG_DATA_W = 10;
	localparam int CFG_IDX_W = 2;

	localparam int PROD_P_W  = 28;
	localparam int PROD_I_W  = 22;
	localparam int ACC_W     = 28;
	// |p*err + i*integ| < 2^26, so the magnitude fits 26 bits
	localparam int MAG_W     = 26;
	// ceil(2^33 / 100): exact floor division by 100 for any 26-bit magnitude
	localparam int RECIP_W     = 27;
	localparam logic [RECIP_W-1:0] RECIP = 27'd85899346;
	localparam int RECIP_SHIFT = 33;
	localparam int DRIVE_W   = 20;

	localparam int PIPE_STAGES = 6;

	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 40;

	localparam logic signed [SPEED_W-1:0] SPEED_MAX = 16'sh7fff;
	localparam logic signed [SPEED_W-1:0] SPEED_MIN = 16'sh8000;

	localparam logic [GAIN_W-1:0] P_GAIN_RST    = 10'd300;
	localparam logic [GAIN_W-1:0] I_GAIN_RST    = 10'd200;
	localparam logic [STEP_W-1:0] RAMP_STEP_RST = 8'd2;
	localparam logic [LIM_W-1:0]  INT_LIMIT_RST = 10'd200;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_P_GAIN    = 2'd0,
		CFG_I_GAIN    = 2'd1,
		CFG_RAMP_STEP = 2'd2,
		CFG_INT_LIMIT = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] p_gain;
		logic [GAIN_W-1:0] i_gain;
		logic [STEP_W-1:0] ramp_step;
		logic [LIM_W-1:0]  integral_limit;
	} cfg_t;

	typedef struct packed {
		logic adv;	// whole pipeline moves one stage
		logic upd;	// valid item in s1: commit wheel state
	} pipe_ctl_t;

endpackage

// File: rtl/dual_wheel_pi_speed_control_top.sv
// ----------------------------------------------------------------------------
// dual_wheel_pi_speed_control_top
// Two-wheel PI speed controller with target ramp and integrator clamp.
//
// Usage:
//   One transfer on the s_axis side is one control tick: both encoder
//   positions, both target speeds and the integrator clear flag. Each tick
//   yields exactly one transfer on the m_axis side with both drive commands.
//   The pipeline takes one tick per cycle while the output is not
//   stalled. The input register feeds the error and integrator stage
//   (wheel state update), then the PI products, the sum, the magnitude
//   and the reciprocal multiply, followed by the output register.
//   When the receiver stalls, the whole pipeline holds and s_axis_tready
//   drops only while a finished result sits unaccepted in the output
//   register.
//   Reset clears the previous encoder positions, ramped targets and
//   integrators to zero and loads the gains, ramp step and limit with their
//   defaults. Registers are written through cfg_we/cfg_index/cfg_data, by
//   the user only while no tick is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module dual_wheel_pi_speed_control_top
	import dwpi_pkg::*;
#(
	parameter int ENCODER_BITS = ENCODER_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// encoder_left, encoder_right, target_left, target_right, clear_integral
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// drive_left, drive_right
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t                     cfg_q;
	pipe_ctl_t                ctl;
	logic [PIPE_STAGES-1:0]   valid_q;
	logic                     out_valid_q;

	logic [ENC_IN_W-1:0]      enc_l_s1, enc_r_s1;
	logic signed [TGT_W-1:0]  tgt_l_s1, tgt_r_s1;
	logic                     clear_s1;

	logic signed [ACC_W-1:0]   acc_l_s4, acc_r_s4;
	logic signed [DRIVE_W-1:0] drive_l_q, drive_r_q;

	always_comb begin
		ctl.adv = !out_valid_q || m_axis_tready;
		ctl.upd = ctl.adv && valid_q[0];
	end

	assign s_axis_tready = ctl.adv;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {drive_r_q, drive_l_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.p_gain         <= P_GAIN_RST;
			cfg_q.i_gain         <= I_GAIN_RST;
			cfg_q.ramp_step      <= RAMP_STEP_RST;
			cfg_q.integral_limit <= INT_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_P_GAIN:    cfg_q.p_gain         <= cfg_data[GAIN_W-1:0];
				CFG_I_GAIN:    cfg_q.i_gain         <= cfg_data[GAIN_W-1:0];
				CFG_RAMP_STEP: cfg_q.ramp_step      <= cfg_data[STEP_W-1:0];
				CFG_INT_LIMIT: cfg_q.integral_limit <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (ctl.adv) begin
			valid_q     <= {valid_q[PIPE_STAGES-2:0], s_axis_tvalid};
			out_valid_q <= valid_q[PIPE_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			enc_l_s1 <= s_axis_tdata[31:0];
			enc_r_s1 <= s_axis_tdata[63:32];
			tgt_l_s1 <= $signed(s_axis_tdata[73:64]);
			tgt_r_s1 <= $signed(s_axis_tdata[83:74]);
			clear_s1 <= s_axis_tdata[84];
		end
	end

	dwpi_wheel #(.ENCODER_BITS(ENCODER_BITS)) u_wheel_l (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.cfg            (cfg_q),
		.encoder        (enc_l_s1),
		.target         (tgt_l_s1),
		.clear_integral (clear_s1),
		.acc_s4         (acc_l_s4)
	);

	dwpi_wheel #(.ENCODER_BITS(ENCODER_BITS)) u_wheel_r (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.cfg            (cfg_q),
		.encoder        (enc_r_s1),
		.target         (tgt_r_s1),
		.clear_integral (clear_s1),
		.acc_s4         (acc_r_s4)
	);

	dwpi_scale u_scale_l (
		.clk     (clk),
		.ctl     (ctl),
		.acc_s4  (acc_l_s4),
		.drive_q (drive_l_q)
	);

	dwpi_scale u_scale_r (
		.clk     (clk),
		.ctl     (ctl),
		.acc_s4  (acc_r_s4),
		.drive_q (drive_r_q)
	);

endmodule

// File: rtl/dwpi_wheel.sv
// ----------------------------------------------------------------------------
// dwpi_wheel
// Per-wheel speed estimate, target ramp, clamped integrator and PI products.
// ----------------------------------------------------------------------------
module dwpi_wheel
	import dwpi_pkg::*;
#(
	parameter int ENCODER_BITS = ENCODER_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pipe_ctl_t                ctl,
	input  cfg_t                     cfg,
	input  logic [ENC_IN_W-1:0]      encoder,
	input  logic signed [TGT_W-1:0]  target,
	input  logic                     clear_integral,
	output logic signed [ACC_W-1:0]  acc_s4
);

	logic signed [ENCODER_BITS-1:0] last_pos_q;
	logic signed [TGT_W-1:0]        ramp_q;
	logic signed [INTEG_W-1:0]      integ_q;

	logic signed [ENCODER_BITS-1:0] pos;
	logic signed [ENCODER_BITS-1:0] diff;
	logic [ENCODER_BITS-SPEED_W:0]  diff_hi;
	logic signed [SPEED_W-1:0]      speed;
	logic signed [RAMP_W-1:0]       ramp_x, tgt_x, step_x, ramp_up, ramp_dn;
	logic signed [TGT_W-1:0]        ramp_nx;
	logic signed [ERR_W-1:0]        err;
	logic signed [INTEG_W-1:0]      integ_base;
	logic signed [SUM_W-1:0]        integ_sum, lim_x;
	logic signed [INTEG_W-1:0]      integ_nx;

	logic signed [ERR_W-1:0]        err_s2;
	logic signed [INTEG_W-1:0]      integ_s2;
	logic signed [PROD_P_W-1:0]     prod_p_s3;
	logic signed [PROD_I_W-1:0]     prod_i_s3;

	always_comb begin
		pos     = ENCODER_BITS'($signed(encoder));
		diff    = pos - last_pos_q;
		diff_hi = diff[ENCODER_BITS-1:SPEED_W-1];
		// saturate when the upper bits are not all copies of the sign
		if ((&diff_hi) || !(|diff_hi)) begin
			speed = diff[SPEED_W-1:0];
		end else begin
			speed = diff[ENCODER_BITS-1] ? SPEED_MIN : SPEED_MAX;
		end

		ramp_x  = RAMP_W'(ramp_q);
		tgt_x   = RAMP_W'(target);
		step_x  = $signed({{(RAMP_W-STEP_W){1'b0}}, cfg.ramp_step});
		ramp_up = ramp_x + step_x;
		ramp_dn = ramp_x - step_x;
		if (tgt_x > ramp_up) begin
			ramp_nx = TGT_W'(ramp_up);
		end else if (tgt_x < ramp_dn) begin
			ramp_nx = TGT_W'(ramp_dn);
		end else begin
			ramp_nx = target;
		end

		err = ERR_W'(ramp_nx) - ERR_W'(speed);

		integ_base = clear_integral ? '0 : integ_q;
		integ_sum  = SUM_W'(integ_base) + SUM_W'(err);
		lim_x      = $signed({{(SUM_W-LIM_W){1'b0}}, cfg.integral_limit});
		if (integ_sum > lim_x) begin
			integ_nx = INTEG_W'(lim_x);
		end else if (integ_sum < -lim_x) begin
			integ_nx = INTEG_W'(-lim_x);
		end else begin
			integ_nx = INTEG_W'(integ_sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pos_q <= '0;
			ramp_q     <= '0;
			integ_q    <= '0;
		end else if (ctl.upd) begin
			last_pos_q <= pos;
			ramp_q     <= ramp_nx;
			integ_q    <= integ_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			err_s2    <= err;
			integ_s2  <= integ_nx;
			prod_p_s3 <= PROD_P_W'($signed({1'b0, cfg.p_gain})) * PROD_P_W'(err_s2);
			prod_i_s3 <= PROD_I_W'($signed({1'b0, cfg.i_gain})) * PROD_I_W'(integ_s2);
			acc_s4    <= ACC_W'(prod_p_s3) + ACC_W'(prod_i_s3);
		end
	end

endmodule

// File: rtl/dwpi_scale.sv
// ----------------------------------------------------------------------------
// dwpi_scale
// Signed divide by 100, truncating toward zero, via reciprocal multiply.
// ----------------------------------------------------------------------------
module dwpi_scale
	import dwpi_pkg::*;
(
	input  logic                      clk,
	input  pipe_ctl_t                 ctl,
	input  logic signed [ACC_W-1:0]   acc_s4,
	output logic signed [DRIVE_W-1:0] drive_q
);

	localparam int PROD_W = MAG_W + RECIP_W;

	logic [ACC_W-1:0]   abs_full;
	logic [MAG_W-1:0]   mag_s5;
	logic               neg_s5, neg_s6;
	logic [PROD_W-1:0]  prod_s6;
	logic [DRIVE_W-1:0] quo, drive_nx;

	always_comb begin
		abs_full = acc_s4[ACC_W-1] ? ACC_W'(-acc_s4) : ACC_W'(acc_s4);
		quo      = prod_s6[RECIP_SHIFT +: DRIVE_W];
		drive_nx = neg_s6 ? DRIVE_W'(-quo) : quo;
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			mag_s5  <= abs_full[MAG_W-1:0];
			neg_s5  <= acc_s4[ACC_W-1];
			prod_s6 <= PROD_W'(mag_s5) * PROD_W'(RECIP);
			neg_s6  <= neg_s5;
			drive_q <= $signed(drive_nx);
		end
	end

endmodule

// File: rtl/dwpi_chk.sv
// ----------------------------------------------------------------------------
// dwpi_chk
// Port-level checks for the speed controller, bound to the top level.
// ----------------------------------------------------------------------------
module dwpi_chk
	import dwpi_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// input side is held only by an unaccepted result
	a_ready_link: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("s_axis_tready does not follow output register state");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("result valid straight out of reset");

endmodule

bind dual_wheel_pi_speed_control_top dwpi_chk u_dwpi_chk (.*);

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dual wheel PI speed controller. Ticks go in as
// stream transfers. Each accepted tick is run through a behavioral model of
// both wheels (wrapped and saturated speed, target ramp, clamped integrator,
// PI sum over 100). The drive pair that results is queued and compared field
// by field with each output transfer. The bench runs directed corner cases
// first, then random well-formed motion under several register settings,
// with random bursts, gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_top
	import dwpi_pkg::*;
();

	typedef struct packed {
		logic        clr;
		logic [9:0]  tgt_r;
		logic [9:0]  tgt_l;
		logic [31:0] enc_r;
		logic [31:0] enc_l;
	} tick_t;

	typedef struct packed {
		logic [DRIVE_W-1:0] right;
		logic [DRIVE_W-1:0] left;
	} drive_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_we = 1'b0;
	cfg_idx_t               cfg_index = CFG_P_GAIN;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// model state of the controller
	cfg_t        gains;
	logic [31:0] last_pos [2];
	int          ramp_tgt [2];
	int          integ [2];

	// stimulus state: running encoder positions and target speeds
	logic [31:0] run_pos [2];
	int          run_tgt [2];

	drive_t      expected_drive [$];
	int          mismatch_count = 0;
	drive_t      got_drive;
	drive_t      want_drive;

	// output side stall control
	int          hold_len = 0;
	int          rx_mode = 0;
	int          rx_left = 0;

	dual_wheel_pi_speed_control_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// one wheel for one tick; updates that wheel's model state
	function automatic logic [DRIVE_W-1:0] wheel_drive(int w, logic [31:0] pos, int target,
			logic clr);
		logic [31:0] delta;
		longint      diff;
		longint      acc;
		longint      pg;
		longint      ig;
		int          speed;
		int          step;
		int          err;
		int          lim;
		int          sum;
		delta = pos - last_pos[w];
		diff = $signed(delta);
		last_pos[w] = pos;
		if (diff > 32767)
			diff = 32767;
		else if (diff < -32768)
			diff = -32768;
		speed = int'(diff);

		step = gains.ramp_step;
		if (target > ramp_tgt[w] + step)
			ramp_tgt[w] = ramp_tgt[w] + step;
		else if (target < ramp_tgt[w] - step)
			ramp_tgt[w] = ramp_tgt[w] - step;
		else
			ramp_tgt[w] = target;

		err = ramp_tgt[w] - speed;
		if (clr)
			integ[w] = 0;
		lim = gains.integral_limit;
		sum = integ[w] + err;
		if (sum > lim)
			sum = lim;
		else if (sum < -lim)
			sum = -lim;
		integ[w] = sum;

		pg = gains.p_gain;
		ig = gains.i_gain;
		acc = (pg * err + ig * integ[w]) / 100;	// signed divide truncates toward zero
		return acc[DRIVE_W-1:0];
	endfunction

	function automatic drive_t predict_drive(tick_t t);
		drive_t d;
		d.left  = wheel_drive(0, t.enc_l, $signed(t.tgt_l), t.clr);
		d.right = wheel_drive(1, t.enc_r, $signed(t.tgt_r), t.clr);
		return d;
	endfunction

	function automatic tick_t mk_tick(logic [31:0] el, logic [31:0] er, int tl, int tr,
			logic clr);
		tick_t t;
		t.enc_l = el;
		t.enc_r = er;
		t.tgt_l = tl[9:0];
		t.tgt_r = tr[9:0];
		t.clr   = clr;
		return t;
	endfunction

	// output checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_drive = m_axis_tdata;
			if (expected_drive.size() == 0) begin
				$display("%0t: drive transfer with none pending: left %0d right %0d",
					$time, $signed(got_drive.left), $signed(got_drive.right));
				mismatch_count++;
			end else begin
				want_drive = expected_drive.pop_front();
				if (got_drive.left !== want_drive.left) begin
					$display("%0t: drive_left expected %0d got %0d", $time,
						$signed(want_drive.left), $signed(got_drive.left));
					mismatch_count++;
				end
				if (got_drive.right !== want_drive.right) begin
					$display("%0t: drive_right expected %0d got %0d", $time,
						$signed(want_drive.right), $signed(got_drive.right));
					mismatch_count++;
				end
			end
		end
	end

	// receiver: long hold-off on request, otherwise a changing stall pattern
	always @(posedge clk) begin
		if (hold_len > 0) begin
			m_axis_tready <= 1'b0;
			hold_len = hold_len - 1;
		end else begin
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = $urandom_range(10, 150);
			end
			rx_left = rx_left - 1;
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				2: m_axis_tready <= ($urandom_range(0, 5) == 0);
				default: m_axis_tready <= rx_left[2];
			endcase
		end
	end

	// tvalid is left high so back-to-back calls keep the bus full
	task automatic send_tick(tick_t t);
		s_axis_tdata  <= {3'b000, t};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_drive.push_back(predict_drive(t));
	endtask

	task automatic pause_sender(int n);
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// every result back, then a further idle margin before touching registers
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_drive.size() != 0)
			@(posedge clk);
		repeat (PIPE_STAGES + 4) @(posedge clk);
	endtask

	task automatic load_gains(logic [GAIN_W-1:0] p, logic [GAIN_W-1:0] i,
			logic [STEP_W-1:0] step, logic [LIM_W-1:0] lim);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_P_GAIN;
		cfg_data  <= p;
		@(posedge clk);
		cfg_index <= CFG_I_GAIN;
		cfg_data  <= i;
		@(posedge clk);
		cfg_index <= CFG_RAMP_STEP;
		cfg_data  <= {2'b00, step};
		@(posedge clk);
		cfg_index <= CFG_INT_LIMIT;
		cfg_data  <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
		gains.p_gain         = p;
		gains.i_gain         = i;
		gains.ramp_step      = step;
		gains.integral_limit = lim;
	endtask

	// mostly smooth motion near the target, some hard jumps and restarts
	task automatic random_tick(output tick_t t);
		int unsigned sel;
		int          delta;
		for (int w = 0; w < 2; w++) begin
			sel = $urandom_range(0, 99);
			if (sel < 15)
				run_tgt[w] = int'($urandom_range(0, 1023)) - 512;
			else if (sel < 60)
				run_tgt[w] = run_tgt[w] + int'($urandom_range(0, 40)) - 20;
			if (run_tgt[w] > 511)
				run_tgt[w] = 511;
			else if (run_tgt[w] < -512)
				run_tgt[w] = -512;
			sel = $urandom_range(0, 99);
			if (sel < 60)
				delta = run_tgt[w] + int'($urandom_range(0, 30)) - 15;
			else if (sel < 88)
				delta = int'($urandom_range(0, 1400)) - 700;
			else
				delta = $urandom;
			if (sel >= 95)
				run_pos[w] = $urandom;
			else
				run_pos[w] = run_pos[w] + delta;
		end
		t = mk_tick(run_pos[0], run_pos[1], run_tgt[0], run_tgt[1],
			$urandom_range(0, 15) == 0);
	endtask

	task automatic run_items(int n);
		tick_t t;
		int    sent;
		int    burst;
		sent = 0;
		while (sent < n) begin
			burst = $urandom_range(1, 40);
			for (int i = 0; i < burst && sent < n; i++) begin
				random_tick(t);
				send_tick(t);
				sent++;
			end
			if ($urandom_range(0, 2) == 0)
				pause_sender(0);
			else
				pause_sender($urandom_range(1, 12));
		end
	endtask

	// ---- directed tests ----

	task automatic test_first_tick();
		send_tick(mk_tick(32'd1000, -32'sd1000, 511, -512, 1'b0));
		send_tick(mk_tick(32'd1003, -32'sd1003, 511, -512, 1'b0));
	endtask

	task automatic test_encoder_jumps();
		send_tick(mk_tick(32'h7fff_ffff, 32'h8000_0000, 0, 0, 1'b0));
		send_tick(mk_tick(32'h8000_0000, 32'h7fff_ffff, 0, 0, 1'b0));
		send_tick(mk_tick(32'h0000_0000, 32'hffff_ffff, 0, 0, 1'b0));
		send_tick(mk_tick(32'hffff_ffff, 32'h0000_0000, 0, 0, 1'b1));
	endtask

	task automatic test_ramp_extremes();
		wait_idle();
		load_gains(P_GAIN_RST, I_GAIN_RST, 8'd0, INT_LIMIT_RST);	// zero ramp step
		send_tick(mk_tick(32'hffff_ffff, 32'h0000_0000, 300, -300, 1'b0));
		send_tick(mk_tick(32'hffff_ffff, 32'h0000_0000, 300, -300, 1'b0));
		send_tick(mk_tick(32'hffff_fff0, 32'h0000_0010, 0, 0, 1'b0));
		wait_idle();
		load_gains(P_GAIN_RST, I_GAIN_RST, 8'd255, INT_LIMIT_RST);
		send_tick(mk_tick(32'hffff_fff0, 32'h0000_0010, 511, -512, 1'b0));
		send_tick(mk_tick(32'hffff_fff0, 32'h0000_0010, 511, -512, 1'b0));
		send_tick(mk_tick(32'hffff_fff0, 32'h0000_0010, -512, 511, 1'b0));
	endtask

	task automatic test_integrator_limit();
		wait_idle();
		load_gains(P_GAIN_RST, I_GAIN_RST, 8'd255, 10'd1023);
		send_tick(mk_tick(32'd5000, 32'd5000, 511, -512, 1'b0));
		send_tick(mk_tick(32'd5000, 32'd5000, 511, -512, 1'b0));
		send_tick(mk_tick(32'd5000, 32'd5000, 511, -512, 1'b0));
		wait_idle();
		// lowered limit only bites at the next clamp
		load_gains(P_GAIN_RST, I_GAIN_RST, 8'd255, 10'd5);
		send_tick(mk_tick(32'd5000, 32'd5000, 511, -512, 1'b0));
		send_tick(mk_tick(32'd5100, 32'd4900, 20, -20, 1'b0));
		wait_idle();
		load_gains(P_GAIN_RST, I_GAIN_RST, 8'd255, 10'd0);
		send_tick(mk_tick(32'd5100, 32'd4900, 511, -512, 1'b1));
		send_tick(mk_tick(32'd5200, 32'd4800, 511, -512, 1'b0));
	endtask

	task automatic test_gain_extremes();
		wait_idle();
		load_gains(10'd1023, 10'd1023, 8'd255, 10'd1023);
		send_tick(mk_tick(32'h7fff_0000, 32'h8001_0000, -512, 511, 1'b0));
		send_tick(mk_tick(32'h0000_0000, 32'h0000_0000, -512, 511, 1'b0));
		wait_idle();
		load_gains(10'd0, 10'd0, 8'd1, 10'd0);
		send_tick(mk_tick(32'h0000_1234, 32'hffff_1234, 511, -512, 1'b1));
	endtask

	// output held off while ticks keep coming, then the sender drains fully
	task automatic test_backpressure();
		tick_t t;
		wait_idle();
		load_gains(P_GAIN_RST, I_GAIN_RST, RAMP_STEP_RST, INT_LIMIT_RST);
		hold_len = 150;
		for (int i = 0; i < 40; i++) begin
			random_tick(t);
			send_tick(t);
		end
		wait_idle();
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 8; phase++) begin
			wait_idle();
			case (phase)
				0: load_gains(10'd1023, 10'd1023, 8'd255, 10'd1023);
				1: load_gains(10'd0, 10'd0, 8'd1, 10'd0);
				2: load_gains(P_GAIN_RST, I_GAIN_RST, RAMP_STEP_RST, INT_LIMIT_RST);
				default: load_gains(10'($urandom_range(0, 1023)),
					10'($urandom_range(0, 1023)), 8'($urandom_range(1, 255)),
					10'($urandom_range(0, 1023)));
			endcase
			run_items(200);
		end
	endtask

	initial begin
		gains.p_gain         = P_GAIN_RST;
		gains.i_gain         = I_GAIN_RST;
		gains.ramp_step      = RAMP_STEP_RST;
		gains.integral_limit = INT_LIMIT_RST;
		for (int w = 0; w < 2; w++) begin
			last_pos[w] = '0;
			ramp_tgt[w] = 0;
			integ[w]    = 0;
			run_pos[w]  = '0;
			run_tgt[w]  = 0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_first_tick();
		test_encoder_jumps();
		test_ramp_extremes();
		test_integrator_limit();
		test_gain_extremes();
		test_backpressure();
		test_random();

		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
